@@ hdl/sks_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_pkg
// Shared widths, register indexes and reset values for the scalar Kalman
// smoother core.
// ----------------------------------------------------------------------------
package sks_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 32;
    localparam int DEN_W    = COEF_W + 1;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [COEF_W-1:0]          coef_t;
    typedef logic [DEN_W-1:0]           den_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    // Configuration register indexes
    localparam cfg_idx_t CFG_PROCESS_NOISE      = 2'd0;
    localparam cfg_idx_t CFG_MEASURE_NOISE      = 2'd1;
    localparam cfg_idx_t CFG_INITIAL_COVARIANCE = 2'd2;

    // Reset values, Q8.24
    localparam coef_t RESET_PROCESS_NOISE      = 32'd1678;
    localparam coef_t RESET_MEASURE_NOISE      = 32'd838861;
    localparam coef_t RESET_INITIAL_COVARIANCE = 32'd167772160;

    // Divider command
    typedef struct packed {
        logic  start;
        coef_t num;
        den_t  den;
    } div_req_t;

endpackage

@@ hdl/scalar_kalman_smoother_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_smoother_core
// One-dimensional Kalman smoother for signed 16-bit samples, Q8.24 covariance.
// ----------------------------------------------------------------------------
// Each sample transaction runs from acceptance to the result through the
// states PRED, DIVGO, DIV, MUL1, MUL2 and UPD; in_stall stays high for that
// whole time. The bit-serial gain divider, one quotient bit per cycle, runs
// in DIV; one shared multiplier then forms the estimate step and the
// covariance update in MUL1 and MUL2, and UPD writes back the state and
// the result. A finished result sits in an output register, and the next
// sample is accepted while it waits; if it still waits when the next result
// is ready, UPD holds until the receiver takes it. Writes to initial_covariance
// are accepted, but the covariance is loaded only by reset, and reset restores
// that register's reset value.
module scalar_kalman_smoother_core #(
    parameter int FRAC_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [sks_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sks_pkg::COEF_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [sks_pkg::SAMPLE_W-1:0] sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [sks_pkg::SAMPLE_W-1:0] estimate_out
);

    localparam int QW = FRAC_BITS + 1;
    localparam int BW = FRAC_BITS + 2;
    localparam int AWID = 33;
    localparam int MW = AWID + BW;
    localparam int ACCW = FRAC_BITS + 19;
    localparam logic [QW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRED  = 3'd1;
    localparam logic [2:0] S_DIVGO = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MUL1  = 3'd4;
    localparam logic [2:0] S_MUL2  = 3'd5;
    localparam logic [2:0] S_UPD   = 3'd6;

    logic [2:0]                state_reg, state_next;
    sks_pkg::coef_t            q_reg, r_reg;
    sks_pkg::coef_t            cov_reg, cov_next;
    sks_pkg::sample_t          est_reg, est_next;
    sks_pkg::sample_t          smp_reg;
    sks_pkg::sample_t          out_reg;
    logic                      out_valid_reg, out_valid_next;
    sks_pkg::coef_t            p_reg;
    logic signed [16:0]        diff_reg;
    logic [QW-1:0]             gain_reg;
    logic [QW-1:0]             omg_reg;
    logic                      den_zero_reg;
    logic signed [MW-1:0]      prod_reg;
    logic signed [ACCW-1:0]    acc_reg;

    logic [sks_pkg::DEN_W-1:0] sum_pq;
    sks_pkg::den_t             den;
    sks_pkg::div_req_t         div_req;
    logic                      div_done;
    logic [QW-1:0]             div_quo;
    logic signed [AWID-1:0]    mul_a;
    logic signed [BW-1:0]      mul_b;
    logic signed [MW-1:0]      mul_p;
    logic [18:0]               est_shift;
    logic                      est_round;
    logic                      accept;
    logic                      upd_go;

    assign accept = in_valid && (state_reg == S_IDLE);
    assign upd_go = (state_reg == S_UPD) && !(out_valid_reg && out_stall);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= sks_pkg::RESET_PROCESS_NOISE;
            r_reg <= sks_pkg::RESET_MEASURE_NOISE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sks_pkg::CFG_PROCESS_NOISE:      q_reg <= cfg_data;
                sks_pkg::CFG_MEASURE_NOISE:      r_reg <= cfg_data;
                sks_pkg::CFG_INITIAL_COVARIANCE: ;
                default:                         ;
            endcase
        end
    end

    // Predicted covariance, saturated
    assign sum_pq = {1'b0, cov_reg} + {1'b0, q_reg};
    assign den    = {1'b0, p_reg} + {1'b0, r_reg};

    assign div_req.start = (state_reg == S_DIVGO);
    assign div_req.num   = p_reg;
    assign div_req.den   = den;

    sks_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Shared multiplier: gain * diff, then p * (1 - gain)
    always_comb
    begin
        if (state_reg == S_MUL2)
        begin
            mul_a = {1'b0, p_reg};
            mul_b = {1'b0, omg_reg};
        end
        else
        begin
            mul_a = {{(AWID-17){diff_reg[16]}}, diff_reg};
            mul_b = {1'b0, gain_reg};
        end
    end
    assign mul_p = mul_a * mul_b;

    // Truncate toward zero: bump negative values that lost fraction bits
    assign est_shift = acc_reg[ACCW-1:FRAC_BITS];
    assign est_round = acc_reg[ACCW-1] && (acc_reg[FRAC_BITS-1:0] != '0);

    always_comb
    begin
        state_next     = state_reg;
        est_next       = est_reg;
        cov_next       = cov_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PRED;
                end
            end
            S_PRED:  state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_UPD;
            S_UPD:
            begin
                if (upd_go)
                begin
                    est_next       = est_shift[15:0] + 16'(est_round);
                    cov_next       = prod_reg[FRAC_BITS+31:FRAC_BITS];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            est_reg       <= '0;
            cov_reg       <= sks_pkg::RESET_INITIAL_COVARIANCE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            est_reg       <= est_next;
            cov_reg       <= cov_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_reg <= sample;
        end
        if (state_reg == S_PRED)
        begin
            p_reg    <= sum_pq[sks_pkg::COEF_W] ? '1 : sum_pq[sks_pkg::COEF_W-1:0];
            diff_reg <= {smp_reg[15], smp_reg} - {est_reg[15], est_reg};
        end
        if (state_reg == S_DIVGO)
        begin
            den_zero_reg <= (den == '0);
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            gain_reg <= den_zero_reg ? '0 : div_quo;
        end
        if (state_reg == S_MUL1)
        begin
            prod_reg <= mul_p;
            omg_reg  <= ONE - gain_reg;
        end
        if (state_reg == S_MUL2)
        begin
            prod_reg <= mul_p;
            acc_reg  <= {{3{est_reg[15]}}, est_reg, {FRAC_BITS{1'b0}}} + prod_reg[ACCW-1:0];
        end
        if (upd_go)
        begin
            out_reg <= est_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign estimate_out = out_reg;

    // Divider finishes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside divide phase");

    // A new result appears only from the update step
    a_out_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_UPD))
        else $error("result raised without update");

    // One transaction at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted while busy");

    // Scaling by (1 - gain) never grows the covariance
    a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        upd_go |=> (cov_reg <= $past(p_reg)))
        else $error("covariance grew in update");

endmodule

@@ hdl/sks_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_divider
// Restoring divider for the gain: quotient = floor(num * 2^FRAC_BITS / den),
// one quotient bit per cycle, valid when num <= den.
// ----------------------------------------------------------------------------
module sks_divider #(
    parameter int FRAC_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sks_pkg::div_req_t    req,
    output logic                 done,
    output logic [FRAC_BITS:0]   quotient
);

    localparam int QW = FRAC_BITS + 1;
    localparam int CW = $clog2(QW + 1);

    logic [sks_pkg::DEN_W-1:0]   rem_reg, rem_next;
    logic [sks_pkg::DEN_W-1:0]   den_reg;
    logic [QW-1:0]               quo_reg, quo_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        first_reg, first_next;
    logic                        done_reg, done_next;
    logic [sks_pkg::DEN_W:0]     trial;
    logic [sks_pkg::DEN_W:0]     diff;
    logic                        fits;

    // First step compares the numerator itself, later steps shift in a zero
    assign trial = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            rem_next   = {1'b0, req.num};
            quo_next   = '0;
            cnt_next   = CW'(QW);
            first_next = 1'b1;
        end
        else if (cnt_reg != '0)
        begin
            rem_next   = fits ? diff[sks_pkg::DEN_W-1:0] : trial[sks_pkg::DEN_W-1:0];
            quo_next   = {quo_reg[QW-2:0], fits};
            cnt_next   = cnt_reg - CW'(1);
            first_next = 1'b0;
            done_next  = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            den_reg <= req.den;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
